>>> hdl/vn_pkg.sv
// Shared widths and constants for the vector normalize pipeline.
package vn_pkg;
    localparam int COMP_W     = 32;             // Q16.16 component width
    localparam int SQ_W       = 2 * COMP_W;     // exact square / sum width
    localparam int ROOT_W     = SQ_W / 2;       // floor square root width
    localparam int UNIT_SHIFT = 30;             // 2^30 stands for one
    localparam int QUO_W      = UNIT_SHIFT + 1; // quotient never exceeds 2^30
    localparam int REM_W      = ROOT_W + 2;     // root remainder stays below 2*root+1
endpackage

>>> hdl/vn_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a sideband.
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = ROOT_W;

    logic              v_s    [STEPS+1];
    logic [REM_W-1:0]  rem_s  [STEPS+1];
    logic [ROOT_W-1:0] root_s [STEPS+1];
    logic [SQ_W-1:0]   rad_s  [STEPS+1];
    logic [SIDE_W-1:0] side_s [STEPS+1];

    assign v_s[0]    = in_valid;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign rad_s[0]  = in_radicand;
    assign side_s[0] = in_side;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  subtrahend;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic              v_reg;
        logic [REM_W-1:0]  rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SQ_W-1:0]   rad_reg;
        logic [SIDE_W-1:0] side_reg;

        always_comb
        begin
            trial      = {rem_s[i], rad_s[i][SQ_W-1 -: 2]};
            subtrahend = {2'b00, root_s[i], 2'b01};
            take       = (trial >= subtrahend);
            rem_next   = take ? REM_W'(trial - subtrahend) : REM_W'(trial);
            root_next  = {root_s[i][ROOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v_s[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad_s[i][SQ_W-3:0], 2'b00};
                side_reg <= side_s[i];
            end
        end

        assign v_s[i+1]    = v_reg;
        assign rem_s[i+1]  = rem_reg;
        assign root_s[i+1] = root_reg;
        assign rad_s[i+1]  = rad_reg;
        assign side_s[i+1] = side_reg;
    end

    assign out_valid = v_s[STEPS];
    assign out_root  = root_s[STEPS];
    assign out_side  = side_s[STEPS];
endmodule

>>> hdl/vn_div.sv
// Pipelined restoring divider for (mag * 2^30) / divisor, one quotient bit per stage.
module vn_div
    import vn_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [COMP_W-1:0] in_mag,
    input  logic [ROOT_W-1:0] in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);
    localparam int STEPS = QUO_W;

    logic              v_s    [STEPS+1];
    logic [ROOT_W-1:0] rem_s  [STEPS+1];
    logic [QUO_W-1:0]  low_s  [STEPS+1];
    logic [QUO_W-1:0]  quot_s [STEPS+1];
    logic [ROOT_W-1:0] div_s  [STEPS+1];
    logic [SIDE_W-1:0] side_s [STEPS+1];

    // Upper dividend bits start as the remainder; they are known to sit below the divisor.
    assign v_s[0]    = in_valid;
    assign rem_s[0]  = ROOT_W'(in_mag[COMP_W-1:1]);
    assign low_s[0]  = {in_mag[0], {(QUO_W-1){1'b0}}};
    assign quot_s[0] = '0;
    assign div_s[0]  = in_divisor;
    assign side_s[0] = in_side;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic [ROOT_W:0]   trial;
        logic              take;
        logic [ROOT_W-1:0] rem_next;
        logic              v_reg;
        logic [ROOT_W-1:0] rem_reg;
        logic [QUO_W-1:0]  low_reg;
        logic [QUO_W-1:0]  quot_reg;
        logic [ROOT_W-1:0] div_reg;
        logic [SIDE_W-1:0] side_reg;

        always_comb
        begin
            trial    = {rem_s[i], low_s[i][QUO_W-1]};
            take     = (trial >= {1'b0, div_s[i]});
            rem_next = take ? ROOT_W'(trial - {1'b0, div_s[i]}) : ROOT_W'(trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v_s[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                low_reg  <= {low_s[i][QUO_W-2:0], 1'b0};
                quot_reg <= {quot_s[i][QUO_W-2:0], take};
                div_reg  <= div_s[i];
                side_reg <= side_s[i];
            end
        end

        assign v_s[i+1]    = v_reg;
        assign rem_s[i+1]  = rem_reg;
        assign low_s[i+1]  = low_reg;
        assign quot_s[i+1] = quot_reg;
        assign div_s[i+1]  = div_reg;
        assign side_s[i+1] = side_reg;
    end

    assign out_valid = v_s[STEPS];
    assign out_quot  = quot_s[STEPS];
    assign out_side  = side_s[STEPS];
endmodule

>>> hdl/vector3_normalize.sv
// Top level of the three-component vector normalize pipeline.
//
// Usage: present a signed Q16.16 vector (comp_x, comp_y, comp_z) with
// in_valid; the word is taken at a rising edge where in_valid is high and
// in_stall is low. Each accepted word yields exactly one result word on
// unit_x/unit_y/unit_z (signed Q1.30), magnitude (unsigned Q16.16, floor
// square root of the exact sum of squares) and was_zero, taken at an edge
// where out_valid is high and out_stall is low.
// Throughput: one word per clock unless out_stall holds the output.
// Pipeline: 67 register stages - 3 for abs/square/sum, 32 square-root
// stages (one root bit each), 31 divider stages (one quotient bit each,
// three lanes in parallel) and the output register.
// Stall: the whole pipeline advances together; while out_valid is high and
// out_stall is asserted every stage holds and in_stall is raised, so no
// word is dropped or duplicated. Bubbles move on whenever the output
// register is empty or being drained.
// Reset: rst_n clears all valid bits; the data registers are not reset.
// A zero vector gives zero outputs with was_zero set.
module vector3_normalize
    import vn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COMP_W-1:0] comp_x,
    input  logic signed [COMP_W-1:0] comp_y,
    input  logic signed [COMP_W-1:0] comp_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COMP_W-1:0] unit_x,
    output logic signed [COMP_W-1:0] unit_y,
    output logic signed [COMP_W-1:0] unit_z,
    output logic [COMP_W-1:0]        magnitude,
    output logic                     was_zero
);
    localparam int SQRT_SIDE_W = 3 * COMP_W + 4;
    localparam int X_SIDE_W    = ROOT_W + 2;

    logic en;

    // Stage A: absolute values, signs, zero detect.
    logic              a_valid_reg;
    logic [COMP_W-1:0] a_mag_reg [3];
    logic [2:0]        a_sign_reg;
    logic              a_zero_reg;

    // Stage B: exact squares.
    logic              b_valid_reg;
    logic [SQ_W-1:0]   b_sq_reg  [3];
    logic [COMP_W-1:0] b_mag_reg [3];
    logic [2:0]        b_sign_reg;
    logic              b_zero_reg;

    // Stage C: sum of squares.
    logic              c_valid_reg;
    logic [SQ_W-1:0]   c_sum_reg;
    logic [COMP_W-1:0] c_mag_reg [3];
    logic [2:0]        c_sign_reg;
    logic              c_zero_reg;

    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    logic [SQRT_SIDE_W-1:0] sq_side;
    logic [COMP_W-1:0]      sq_mag [3];
    logic [2:0]             sq_sign;
    logic                   sq_zero;

    logic                dx_valid, dy_valid, dz_valid;
    logic [QUO_W-1:0]    qx, qy, qz;
    logic [X_SIDE_W-1:0] dx_side;
    logic                dy_sign, dz_sign;
    logic [ROOT_W-1:0]   d_len;
    logic                d_zero, dx_sign;

    logic              out_valid_reg;
    logic [COMP_W-1:0] unit_x_reg, unit_y_reg, unit_z_reg, magnitude_reg;
    logic              was_zero_reg;

    // Advance everything unless a finished word is held at the output.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    function automatic logic [COMP_W-1:0] abs_comp(input logic [COMP_W-1:0] c);
        return c[COMP_W-1] ? (~c + COMP_W'(1)) : c;
    endfunction

    function automatic logic [COMP_W-1:0] apply_sign(input logic sgn, input logic zero,
                                                     input logic [QUO_W-1:0] q);
        logic [COMP_W-1:0] ext;
        ext = COMP_W'(q);
        if (zero)
            return '0;
        return sgn ? (~ext + COMP_W'(1)) : ext;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= dx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg[0] <= abs_comp(comp_x);
            a_mag_reg[1] <= abs_comp(comp_y);
            a_mag_reg[2] <= abs_comp(comp_z);
            a_sign_reg   <= {comp_z[COMP_W-1], comp_y[COMP_W-1], comp_x[COMP_W-1]};
            a_zero_reg   <= (comp_x == '0) && (comp_y == '0) && (comp_z == '0);

            for (int k = 0; k < 3; k++)
            begin
                b_sq_reg[k]  <= SQ_W'(a_mag_reg[k]) * SQ_W'(a_mag_reg[k]);
                b_mag_reg[k] <= a_mag_reg[k];
                c_mag_reg[k] <= b_mag_reg[k];
            end
            b_sign_reg <= a_sign_reg;
            b_zero_reg <= a_zero_reg;

            c_sum_reg  <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_sign_reg <= b_sign_reg;
            c_zero_reg <= b_zero_reg;

            unit_x_reg    <= apply_sign(dx_sign, d_zero, qx);
            unit_y_reg    <= apply_sign(dy_sign, d_zero, qy);
            unit_z_reg    <= apply_sign(dz_sign, d_zero, qz);
            magnitude_reg <= d_len;
            was_zero_reg  <= d_zero;
        end
    end

    vn_sqrt #(
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (c_valid_reg),
        .in_radicand (c_sum_reg),
        .in_side     ({c_zero_reg, c_sign_reg, c_mag_reg[2], c_mag_reg[1], c_mag_reg[0]}),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_side    (sq_side)
    );

    assign sq_mag[0] = sq_side[COMP_W-1:0];
    assign sq_mag[1] = sq_side[2*COMP_W-1:COMP_W];
    assign sq_mag[2] = sq_side[3*COMP_W-1:2*COMP_W];
    assign sq_sign   = sq_side[3*COMP_W+2:3*COMP_W];
    assign sq_zero   = sq_side[3*COMP_W+3];

    // Lane x also carries the length and zero flag to the output.
    vn_div #(
        .SIDE_W (X_SIDE_W)
    ) u_div_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_mag     (sq_mag[0]),
        .in_divisor (sq_root),
        .in_side    ({sq_zero, sq_sign[0], sq_root}),
        .out_valid  (dx_valid),
        .out_quot   (qx),
        .out_side   (dx_side)
    );

    vn_div #(
        .SIDE_W (1)
    ) u_div_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_mag     (sq_mag[1]),
        .in_divisor (sq_root),
        .in_side    (sq_sign[1]),
        .out_valid  (dy_valid),
        .out_quot   (qy),
        .out_side   (dy_sign)
    );

    vn_div #(
        .SIDE_W (1)
    ) u_div_z (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_mag     (sq_mag[2]),
        .in_divisor (sq_root),
        .in_side    (sq_sign[2]),
        .out_valid  (dz_valid),
        .out_quot   (qz),
        .out_side   (dz_sign)
    );

    assign d_len   = dx_side[ROOT_W-1:0];
    assign dx_sign = dx_side[ROOT_W];
    assign d_zero  = dx_side[ROOT_W+1];

    assign out_valid = out_valid_reg;
    assign unit_x    = unit_x_reg;
    assign unit_y    = unit_y_reg;
    assign unit_z    = unit_z_reg;
    assign magnitude = magnitude_reg;
    assign was_zero  = was_zero_reg;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (dy_valid == dx_valid) && (dz_valid == dx_valid))
        else $error("divider lanes out of step");

    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not track output hold");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_zero) |-> (magnitude == '0 && unit_x == '0
                                     && unit_y == '0 && unit_z == '0))
        else $error("zero vector produced nonzero result");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (unit_x >= -(32'sd1 <<< UNIT_SHIFT) && unit_x <= (32'sd1 <<< UNIT_SHIFT)))
        else $error("unit_x out of range");

    a_nonzero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !was_zero) |-> (magnitude != '0))
        else $error("nonzero vector with zero length");
endmodule

>>> dv/vector3_normalize_tb.sv
// Self-checking testbench for the vector3_normalize pipeline.
module vector3_normalize_tb;
    import vn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] ux;
        logic signed [COMP_W-1:0] uy;
        logic signed [COMP_W-1:0] uz;
        logic [COMP_W-1:0]        mag;
        logic                     zero;
    } unit_vec_t;

    localparam int PIPE_LAT   = 67;
    localparam int HOLD_LEN   = 400;
    localparam longint CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COMP_W-1:0] comp_x = '0;
    logic signed [COMP_W-1:0] comp_y = '0;
    logic signed [COMP_W-1:0] comp_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic [COMP_W-1:0] magnitude;
    logic was_zero;

    vector3_normalize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .magnitude (magnitude),
        .was_zero  (was_zero)
    );

    vec_t      pending_vecs[$];
    unit_vec_t expected_units[$];
    int        mismatch_cnt = 0;
    longint    cycle_cnt = 0;
    bit        quiet_tx = 1'b1;      // no random gaps on the sender
    bit        quiet_rx = 1'b1;      // no random stalls on the receiver
    bit        hold_req = 1'b0;      // ask for one long receiver hold
    int        hold_left = 0;
    bit        drain_pause = 1'b0;   // sender waits for all results

    initial begin
        forever #5 clk = ~clk;
    end

    // Floor square root of a 64-bit value, bit by bit.
    function automatic logic [ROOT_W-1:0] isqrt64(logic [SQ_W-1:0] n);
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] probe;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= n)
                root = probe;
        end
        return root[ROOT_W-1:0];
    endfunction

    // Work out the expected unit vector and length of one input word.
    function automatic unit_vec_t normalize_vec(vec_t v);
        unit_vec_t r;
        logic [SQ_W-1:0] ax, ay, az, sum;
        logic [SQ_W-1:0] len;
        logic [SQ_W-1:0] mags[3];
        logic [SQ_W-1:0] q;
        logic [COMP_W-1:0] res[3];
        logic signs[3];
        ax = v.x[COMP_W-1] ? 64'(-{{32{v.x[31]}}, v.x}) : 64'(v.x);
        ay = v.y[COMP_W-1] ? 64'(-{{32{v.y[31]}}, v.y}) : 64'(v.y);
        az = v.z[COMP_W-1] ? 64'(-{{32{v.z[31]}}, v.z}) : 64'(v.z);
        sum = ax * ax + ay * ay + az * az;
        r = '0;
        if (sum == 0) begin
            r.zero = 1'b1;
            return r;
        end
        len = 64'(isqrt64(sum));
        mags[0] = ax; mags[1] = ay; mags[2] = az;
        signs[0] = v.x[31]; signs[1] = v.y[31]; signs[2] = v.z[31];
        for (int i = 0; i < 3; i++) begin
            q = (mags[i] << UNIT_SHIFT) / len;
            if (signs[i])
                q = -q;
            res[i] = q[COMP_W-1:0];
        end
        r.ux = res[0]; r.uy = res[1]; r.uz = res[2];
        r.mag = len[COMP_W-1:0];
        return r;
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return $urandom >> $urandom_range(0, 31);
            4: return -($urandom >> $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    logic accepted;
    always @(posedge clk) begin
        accepted <= in_valid && !in_stall && rst_n;
    end

    // Driver: advance to the next word only after the current one is taken.
    always @(negedge clk) begin
        if (rst_n) begin
            if (accepted || !in_valid) begin
                // Either the last word went or nothing is offered: choose next.
                if (pending_vecs.size() > 0 && !drain_pause
                    && (quiet_tx || $urandom_range(0, 99) >= 27)) begin
                    vec_t v;
                    v = pending_vecs.pop_front();
                    comp_x <= v.x;
                    comp_y <= v.y;
                    comp_z <= v.z;
                    in_valid <= 1'b1;
                    expected_units.push_back(normalize_vec(v));
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold on request.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req && hold_left == 0) begin
                hold_left <= HOLD_LEN;
                hold_req <= 1'b0;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left > 1);
            end else begin
                out_stall <= !quiet_rx && ($urandom_range(0, 99) < 27);
            end
        end
    end

    // Monitor: compare each result word against the oldest expectation.
    always @(posedge clk) begin
        unit_vec_t got, want;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && out_valid && !out_stall) begin
            got = '{unit_x, unit_y, unit_z, magnitude, was_zero};
            if (expected_units.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result word: %p", got);
            end else begin
                want = expected_units.pop_front();
                if (got !== want) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_vec(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                            logic [COMP_W-1:0] z);
        vec_t v;
        v.x = x; v.y = y; v.z = z;
        pending_vecs.push_back(v);
    endtask

    task automatic wait_drained();
        while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        int wait_cnt;
        // Directed: zero vector, extremes, single axes, both signs.
        push_vec(0, 0, 0);
        push_vec(32'h8000_0000, 0, 0);
        push_vec(0, 32'h8000_0000, 0);
        push_vec(0, 0, 32'h8000_0000);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_vec(1, 0, 0);
        push_vec(0, 32'hffff_ffff, 0);
        push_vec(0, 0, 1);
        push_vec(1, 1, 1);
        push_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_vec(32'h0001_0000, 0, 0);
        push_vec(32'h0003_0000, 32'h0004_0000, 0);
        push_vec(32'hfffd_0000, 32'h0004_0000, 32'hffff_0000);
        push_vec(1, 32'h7fff_ffff, 32'hffff_ffff);
        push_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed and first random words with no idling on either side.
        for (int i = 0; i < 300; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp());
        wait_drained();

        // Random idling on both sides.
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        for (int i = 0; i < 700; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp());
        // Hold the receiver off long enough to fill the pipeline.
        hold_req = 1'b1;
        wait_drained();

        for (int i = 0; i < 900; i++)
            push_vec(rand_comp(), rand_comp(), rand_comp());

        // Mid-stream, the sender pauses until everything expected has arrived.
        repeat (300) @(posedge clk);
        drain_pause = 1'b1;
        while (in_valid || expected_units.size() > 0)
            @(posedge clk);
        drain_pause = 1'b0;
        wait_drained();

        // Let any stray word surface before judging.
        wait_cnt = 0;
        while (wait_cnt < PIPE_LAT + 20) begin
            @(posedge clk);
            wait_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
